/* rtl/core/assert_macros.svh */
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define ASSERT_IMPL(lbl, clk, rstn, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (pre) |-> (post)) \
        else $error("same-cycle check failed");

`define ASSERT_NEXT(lbl, clk, rstn, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (pre) |=> (post)) \
        else $error("next-cycle check failed");

`else

`define ASSERT_IMPL(lbl, clk, rstn, pre, post)

`define ASSERT_NEXT(lbl, clk, rstn, pre, post)

`endif

`endif

/* rtl/core/csbc_pkg.sv */
`default_nettype none

package csbc_pkg;

    localparam int VW  = 20;
    localparam int LW  = 19;
    localparam int NCH = 3;
    localparam int IW  = 2;

    localparam logic [LW-1:0] LIMIT_RESET = 19'd65536;

    localparam logic signed [VW-1:0] VAL_MAX = {1'b0, {(VW-1){1'b1}}};
    localparam logic signed [VW-1:0] VAL_MIN = {1'b1, {(VW-1){1'b0}}};

    typedef enum logic [IW-1:0] {
        REG_LIMIT_RED   = 2'd0,
        REG_LIMIT_GREEN = 2'd1,
        REG_LIMIT_BLUE  = 2'd2
    } t_reg_idx;

    typedef struct packed {
        logic [NCH-1:0][VW-1:0] lo;
        logic [NCH-1:0][VW-1:0] hi;
    } t_pair;

    typedef struct packed {
        logic cross_z;
        logic mvhi_z;
        logic cross_l;
        logic mvhi_l;
    } t_flags;

    function automatic logic [VW:0] mag21(input logic signed [VW:0] v);
        logic [VW:0] r;
        r = v[VW] ? (VW+1)'(0) - v : v;
        return r;
    endfunction

endpackage

`default_nettype wire

/* rtl/core/csbc_setup_cell.sv */
`default_nettype none

module csbc_setup_cell #(
    parameter int CH = 0
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_en,
    input  logic                   i_valid,
    input  csbc_pkg::t_pair        i_pair,
    input  logic [csbc_pkg::LW-1:0] i_limit,
    output logic                   o_valid,
    output csbc_pkg::t_pair        o_pair,
    output csbc_pkg::t_flags       o_flags,
    output logic [csbc_pkg::VW:0]  o_den,
    output logic [csbc_pkg::VW:0]  o_rem_z,
    output logic [csbc_pkg::VW:0]  o_rem_l,
    output logic                   o_bit_z,
    output logic                   o_bit_l
);
    import csbc_pkg::*;

    logic signed [VW:0] l0, h0, th;
    logic [VW:0]        num_z, num_l, den;
    logic               above_l, above_h;
    t_flags             flags;

    always_comb begin
        l0      = signed'({i_pair.lo[CH][VW-1], i_pair.lo[CH]});
        h0      = signed'({i_pair.hi[CH][VW-1], i_pair.hi[CH]});
        th      = signed'({2'b00, i_limit});
        above_l = l0 > th;
        above_h = h0 > th;
        num_z   = mag21(l0);
        num_l   = mag21(th - l0);
        den     = mag21(h0 - l0);
        flags.cross_z = l0[VW] ^ h0[VW];
        flags.mvhi_z  = !l0[VW];
        flags.cross_l = above_l ^ above_h;
        flags.mvhi_l  = !above_l;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_en) begin
            o_valid <= i_valid;
        end
    end

    // the first divide cell rejoins the whole numerator; later cells shift in zeros
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_pair  <= i_pair;
            o_flags <= flags;
            o_den   <= den;
            o_rem_z <= num_z >> 1;
            o_rem_l <= num_l >> 1;
            o_bit_z <= num_z[0];
            o_bit_l <= num_l[0];
        end
    end

endmodule

`default_nettype wire

/* rtl/core/csbc_div_cell.sv */
`default_nettype none

module csbc_div_cell #(
    parameter int QW = 17
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_en,
    input  logic                   i_valid,
    input  csbc_pkg::t_pair        i_pair,
    input  csbc_pkg::t_flags       i_flags,
    input  logic [csbc_pkg::VW:0]  i_den,
    input  logic [csbc_pkg::VW:0]  i_rem_z,
    input  logic [csbc_pkg::VW:0]  i_rem_l,
    input  logic                   i_bit_z,
    input  logic                   i_bit_l,
    input  logic [QW-1:0]          i_q_z,
    input  logic [QW-1:0]          i_q_l,
    output logic                   o_valid,
    output csbc_pkg::t_pair        o_pair,
    output csbc_pkg::t_flags       o_flags,
    output logic [csbc_pkg::VW:0]  o_den,
    output logic [csbc_pkg::VW:0]  o_rem_z,
    output logic [csbc_pkg::VW:0]  o_rem_l,
    output logic [QW-1:0]          o_q_z,
    output logic [QW-1:0]          o_q_l
);
    import csbc_pkg::*;

    logic [VW+1:0] sh_z, sh_l, dx, df_z, df_l;
    logic          ge_z, ge_l;

    // one restoring step per division
    always_comb begin
        sh_z = {i_rem_z, i_bit_z};
        sh_l = {i_rem_l, i_bit_l};
        dx   = {1'b0, i_den};
        ge_z = sh_z >= dx;
        ge_l = sh_l >= dx;
        df_z = ge_z ? sh_z - dx : sh_z;
        df_l = ge_l ? sh_l - dx : sh_l;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_en) begin
            o_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_pair  <= i_pair;
            o_flags <= i_flags;
            o_den   <= i_den;
            o_rem_z <= df_z[VW:0];
            o_rem_l <= df_l[VW:0];
            o_q_z   <= {i_q_z[QW-2:0], ge_z};
            o_q_l   <= {i_q_l[QW-2:0], ge_l};
        end
    end

endmodule

`default_nettype wire

/* rtl/core/csbc_move_cell.sv */
`default_nettype none

module csbc_move_cell #(
    parameter int FB  = 16,
    parameter bit LIM = 1'b0
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  csbc_pkg::t_pair  i_pair,
    input  csbc_pkg::t_flags i_flags,
    input  logic [FB:0]      i_q_z,
    input  logic [FB:0]      i_q_l,
    output logic             o_valid,
    output csbc_pkg::t_pair  o_pair,
    output csbc_pkg::t_flags o_flags,
    output logic [FB:0]      o_q_z,
    output logic [FB:0]      o_q_l
);
    import csbc_pkg::*;

    localparam int TW = FB + 2;
    localparam int DW = VW + 1;
    localparam int PW = DW + TW;
    localparam int SW = PW + 2 - FB;
    localparam logic signed [TW-1:0] ONE  = TW'(1) << FB;
    localparam logic signed [PW:0]   HALF = (PW + 1)'(1) << (FB - 1);

    logic                   mvhi_a, cross_b, mvhi_b;
    logic signed [TW-1:0]   t;
    logic signed [DW-1:0]   d     [NCH];
    logic signed [PW-1:0]   prod  [NCH];

    logic                   r_v1;
    t_pair                  r_pair1;
    t_flags                 r_flags1;
    logic [FB:0]            r_qz1, r_ql1;
    logic signed [PW-1:0]   r_p1  [NCH];

    logic signed [PW:0]     biased;
    logic signed [PW-FB:0]  rnd;
    logic signed [SW-1:0]   sum;
    logic signed [VW-1:0]   tg;
    t_pair                  pair_n;

    // stage 1: signed factor and products
    always_comb begin
        mvhi_a = LIM ? i_flags.mvhi_l : i_flags.mvhi_z;
        t = signed'({1'b0, (LIM ? i_q_l : i_q_z)});
        if (mvhi_a) begin
            t = t - ONE;
        end
        for (int c = 0; c < NCH; c++) begin
            d[c] = signed'({i_pair.hi[c][VW-1], i_pair.hi[c]})
                 - signed'({i_pair.lo[c][VW-1], i_pair.lo[c]});
            prod[c] = PW'(d[c]) * PW'(t);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1    <= 1'b0;
            o_valid <= 1'b0;
        end else if (i_en) begin
            r_v1    <= i_valid;
            o_valid <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pair1  <= i_pair;
            r_flags1 <= i_flags;
            r_qz1    <= i_q_z;
            r_ql1    <= i_q_l;
            for (int c = 0; c < NCH; c++) begin
                r_p1[c] <= prod[c];
            end
        end
    end

    // stage 2: round half up, add, saturate
    always_comb begin
        cross_b = LIM ? r_flags1.cross_l : r_flags1.cross_z;
        mvhi_b  = LIM ? r_flags1.mvhi_l : r_flags1.mvhi_z;
        pair_n  = r_pair1;
        biased  = '0;
        rnd     = '0;
        sum     = '0;
        tg      = '0;
        for (int c = 0; c < NCH; c++) begin
            biased = signed'({r_p1[c][PW-1], r_p1[c]}) + HALF;
            rnd    = biased[PW:FB];
            tg     = signed'(mvhi_b ? r_pair1.hi[c] : r_pair1.lo[c]);
            sum    = SW'(tg) + SW'(rnd);
            if (sum > SW'(VAL_MAX)) begin
                tg = VAL_MAX;
            end else if (sum < SW'(VAL_MIN)) begin
                tg = VAL_MIN;
            end else begin
                tg = sum[VW-1:0];
            end
            if (cross_b) begin
                if (mvhi_b) begin
                    pair_n.hi[c] = tg;
                end else begin
                    pair_n.lo[c] = tg;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_pair  <= pair_n;
            o_flags <= r_flags1;
            o_q_z   <= r_qz1;
            o_q_l   <= r_ql1;
        end
    end

endmodule

`default_nettype wire

/* rtl/core/color_segment_box_clip_unit.sv */
`default_nettype none
`include "assert_macros.svh"

// Clips the RGB segment between two signed fixed-point endpoints to the box
// [0, limit] per channel, red then green then blue, zero side before limit
// side. One word is taken every cycle while o_ready is high. Per channel a
// word passes one setup cell, FRACTION_BITS+1 divide cells that each resolve
// one quotient bit of both crossing factors, and two cells of two stages
// each that move the outside endpoint; after the last channel comes the
// output register. A skid register behind the output register lets one
// more word in while the output stalls.
// Limit registers reset to 1.0 (65536) and are written by index 0..2;
// index 3 is ignored.
module color_segment_box_clip_unit #(
    parameter int FRACTION_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic signed [csbc_pkg::VW-1:0] i_low_red,
    input  logic signed [csbc_pkg::VW-1:0] i_low_green,
    input  logic signed [csbc_pkg::VW-1:0] i_low_blue,
    input  logic signed [csbc_pkg::VW-1:0] i_high_red,
    input  logic signed [csbc_pkg::VW-1:0] i_high_green,
    input  logic signed [csbc_pkg::VW-1:0] i_high_blue,
    input  logic                          i_cfg_we,
    input  logic [csbc_pkg::IW-1:0]       i_cfg_index,
    input  logic [csbc_pkg::LW-1:0]       i_cfg_data,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic signed [csbc_pkg::VW-1:0] o_clipped_low_red,
    output logic signed [csbc_pkg::VW-1:0] o_clipped_low_green,
    output logic signed [csbc_pkg::VW-1:0] o_clipped_low_blue,
    output logic signed [csbc_pkg::VW-1:0] o_clipped_high_red,
    output logic signed [csbc_pkg::VW-1:0] o_clipped_high_green,
    output logic signed [csbc_pkg::VW-1:0] o_clipped_high_blue
);
    import csbc_pkg::*;

    localparam int QW = FRACTION_BITS + 1;

    logic [LW-1:0] r_lim [NCH];
    logic          en;
    logic          ch_valid [NCH+1];
    t_pair         ch_pair  [NCH+1];

    logic          r_out_valid, r_skid_valid, out_free;
    t_pair         r_out_pair, r_skid_pair;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < NCH; c++) begin
                r_lim[c] <= LIMIT_RESET;
            end
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_LIMIT_RED:   r_lim[0] <= i_cfg_data;
                REG_LIMIT_GREEN: r_lim[1] <= i_cfg_data;
                REG_LIMIT_BLUE:  r_lim[2] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign en      = !r_skid_valid;
    assign o_ready = en;

    assign ch_valid[0]   = i_valid;
    assign ch_pair[0].lo = {i_low_blue, i_low_green, i_low_red};
    assign ch_pair[0].hi = {i_high_blue, i_high_green, i_high_red};

    for (genvar ch = 0; ch < NCH; ch++) begin : g_ch
        logic          dv_valid [QW+1];
        t_pair         dv_pair  [QW+1];
        t_flags        dv_flags [QW+1];
        logic [VW:0]   dv_den   [QW+1];
        logic [VW:0]   dv_rz    [QW+1];
        logic [VW:0]   dv_rl    [QW+1];
        logic [QW-1:0] dv_qz    [QW+1];
        logic [QW-1:0] dv_ql    [QW+1];
        logic          s_bit_z, s_bit_l;

        logic          mz_valid;
        t_pair         mz_pair;
        t_flags        mz_flags, ml_flags;
        logic [QW-1:0] mz_qz, mz_ql, ml_qz, ml_ql;

        csbc_setup_cell #(.CH(ch)) u_setup (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (ch_valid[ch]),
            .i_pair  (ch_pair[ch]),
            .i_limit (r_lim[ch]),
            .o_valid (dv_valid[0]),
            .o_pair  (dv_pair[0]),
            .o_flags (dv_flags[0]),
            .o_den   (dv_den[0]),
            .o_rem_z (dv_rz[0]),
            .o_rem_l (dv_rl[0]),
            .o_bit_z (s_bit_z),
            .o_bit_l (s_bit_l)
        );

        assign dv_qz[0] = '0;
        assign dv_ql[0] = '0;

        for (genvar k = 0; k < QW; k++) begin : g_div
            logic b_z, b_l;
            assign b_z = (k == 0) ? s_bit_z : 1'b0;
            assign b_l = (k == 0) ? s_bit_l : 1'b0;

            csbc_div_cell #(.QW(QW)) u_div (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_en    (en),
                .i_valid (dv_valid[k]),
                .i_pair  (dv_pair[k]),
                .i_flags (dv_flags[k]),
                .i_den   (dv_den[k]),
                .i_rem_z (dv_rz[k]),
                .i_rem_l (dv_rl[k]),
                .i_bit_z (b_z),
                .i_bit_l (b_l),
                .i_q_z   (dv_qz[k]),
                .i_q_l   (dv_ql[k]),
                .o_valid (dv_valid[k+1]),
                .o_pair  (dv_pair[k+1]),
                .o_flags (dv_flags[k+1]),
                .o_den   (dv_den[k+1]),
                .o_rem_z (dv_rz[k+1]),
                .o_rem_l (dv_rl[k+1]),
                .o_q_z   (dv_qz[k+1]),
                .o_q_l   (dv_ql[k+1])
            );
        end

        csbc_move_cell #(.FB(FRACTION_BITS), .LIM(1'b0)) u_move_zero (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (dv_valid[QW]),
            .i_pair  (dv_pair[QW]),
            .i_flags (dv_flags[QW]),
            .i_q_z   (dv_qz[QW]),
            .i_q_l   (dv_ql[QW]),
            .o_valid (mz_valid),
            .o_pair  (mz_pair),
            .o_flags (mz_flags),
            .o_q_z   (mz_qz),
            .o_q_l   (mz_ql)
        );

        csbc_move_cell #(.FB(FRACTION_BITS), .LIM(1'b1)) u_move_limit (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (mz_valid),
            .i_pair  (mz_pair),
            .i_flags (mz_flags),
            .i_q_z   (mz_qz),
            .i_q_l   (mz_ql),
            .o_valid (ch_valid[ch+1]),
            .o_pair  (ch_pair[ch+1]),
            .o_flags (ml_flags),
            .o_q_z   (ml_qz),
            .o_q_l   (ml_ql)
        );
    end

    // output register plus skid slot
    assign out_free = !r_out_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_free) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= ch_valid[NCH];
            end
        end else if (en && ch_valid[NCH]) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            r_out_pair <= r_skid_valid ? r_skid_pair : ch_pair[NCH];
        end
        if (!out_free && en) begin
            r_skid_pair <= ch_pair[NCH];
        end
    end

    assign o_valid              = r_out_valid;
    assign o_clipped_low_red    = r_out_pair.lo[0];
    assign o_clipped_low_green  = r_out_pair.lo[1];
    assign o_clipped_low_blue   = r_out_pair.lo[2];
    assign o_clipped_high_red   = r_out_pair.hi[0];
    assign o_clipped_high_green = r_out_pair.hi[1];
    assign o_clipped_high_blue  = r_out_pair.hi[2];

    `ASSERT_IMPL(a_skid_behind_out, i_clk, i_rst_n, r_skid_valid, r_out_valid)
    `ASSERT_NEXT(a_skid_needs_out, i_clk, i_rst_n, !r_out_valid, !r_skid_valid)
    `ASSERT_NEXT(a_skid_holds, i_clk, i_rst_n, r_skid_valid && !i_ready, r_skid_valid)

endmodule

`default_nettype wire

/* verif/color_segment_box_clip_unit_tb.sv */
`default_nettype none

class clip_scoreboard;
    typedef struct {
        logic signed [19:0] lo [3];
        logic signed [19:0] hi [3];
    } pair_t;

    pair_t pending[$];
    int unsigned errors;
    longint unsigned lim [3];

    function new();
        errors = 0;
        foreach (lim[c]) lim[c] = 65536;
    endfunction

    function void set_limit(int idx, longint unsigned v);
        if (idx >= 0 && idx < 3) lim[idx] = v & 19'h7FFFF;
    endfunction

    static function longint clamp20(longint v);
        if (v < -524288) return -524288;
        if (v > 524287) return 524287;
        return v;
    endfunction

    // divide by 2^16, rounding half toward +inf (floor of p + half)
    static function longint round_scale(longint p);
        longint b;
        b = p + 32768;
        return b >>> 16;
    endfunction

    static function longint abs64(longint v);
        return v < 0 ? -v : v;
    endfunction

    static function void shift_end(ref longint lo[3], ref longint hi[3], input bit mv_hi,
                                   input longint t);
        longint d;
        for (int c = 0; c < 3; c++) begin
            d = hi[c] - lo[c];
            if (mv_hi) hi[c] = clamp20(hi[c] + round_scale(d * t));
            else lo[c] = clamp20(lo[c] + round_scale(d * t));
        end
    endfunction

    function void note_pair(logic signed [19:0] li[3], logic signed [19:0] hi_in[3]);
        longint lo[3], hi[3];
        longint l0, h0, th, t;
        pair_t p;
        for (int c = 0; c < 3; c++) begin
            lo[c] = li[c];
            hi[c] = hi_in[c];
        end
        for (int c = 0; c < 3; c++) begin
            l0 = lo[c];
            h0 = hi[c];
            th = lim[c];
            if ((l0 < 0) != (h0 < 0)) begin
                t = (abs64(-l0) << 16) / abs64(h0 - l0);
                if (l0 >= 0) t -= 65536;
                shift_end(lo, hi, l0 >= 0, t);
            end
            if ((l0 > th) != (h0 > th)) begin
                t = (abs64(th - l0) << 16) / abs64(h0 - l0);
                if (l0 <= th) t -= 65536;
                shift_end(lo, hi, l0 <= th, t);
            end
        end
        for (int c = 0; c < 3; c++) begin
            p.lo[c] = lo[c][19:0];
            p.hi[c] = hi[c][19:0];
        end
        pending.push_back(p);
    endfunction

    function void check_pair(logic signed [19:0] lo[3], logic signed [19:0] hi[3]);
        pair_t e;
        if (pending.size() == 0) begin
            $display("%0t: unexpected word lo=%0d,%0d,%0d hi=%0d,%0d,%0d", $time,
                     lo[0], lo[1], lo[2], hi[0], hi[1], hi[2]);
            errors++;
            return;
        end
        e = pending.pop_front();
        for (int c = 0; c < 3; c++) begin
            if (lo[c] !== e.lo[c]) begin
                $display("%0t: low ch%0d expected %0d actual %0d", $time, c, e.lo[c], lo[c]);
                errors++;
            end
            if (hi[c] !== e.hi[c]) begin
                $display("%0t: high ch%0d expected %0d actual %0d", $time, c, e.hi[c], hi[c]);
                errors++;
            end
        end
    endfunction
endclass

module color_segment_box_clip_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import csbc_pkg::*;

    localparam int LATENCY = 67;
    localparam longint CYCLE_LIMIT = 400000;

    logic i_clk, i_rst_n, i_valid, o_ready, i_cfg_we, o_valid, i_ready;
    logic signed [VW-1:0] i_low_red, i_low_green, i_low_blue;
    logic signed [VW-1:0] i_high_red, i_high_green, i_high_blue;
    logic [IW-1:0] i_cfg_index;
    logic [LW-1:0] i_cfg_data;
    logic signed [VW-1:0] o_clipped_low_red, o_clipped_low_green, o_clipped_low_blue;
    logic signed [VW-1:0] o_clipped_high_red, o_clipped_high_green, o_clipped_high_blue;

    clip_scoreboard sb;
    longint cycles;
    bit hold_rx;

    color_segment_box_clip_unit dut (.*);

    initial begin
        i_clk = 0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles > CYCLE_LIMIT) begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    // result side: check at rising edge, stall pattern at falling edge
    initial begin
        sb = new();
        i_ready = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && i_ready)
                sb.check_pair('{o_clipped_low_red, o_clipped_low_green, o_clipped_low_blue},
                    '{o_clipped_high_red, o_clipped_high_green, o_clipped_high_blue});
            @(negedge i_clk);
            if (hold_rx) i_ready <= 0;
            else if (cycles % 600 < 150) i_ready <= 1;
            else i_ready <= ($urandom_range(0, 3) != 0);
        end
    end

    task automatic write_limit(t_reg_idx idx, logic [LW-1:0] v);
        i_cfg_we <= 1;
        i_cfg_index <= idx;
        i_cfg_data <= v;
        @(negedge i_clk);
        i_cfg_we <= 0;
        sb.set_limit(int'(idx), v);
    endtask

    task automatic send_pair(logic signed [VW-1:0] a0, a1, a2, b0, b1, b2);
        i_valid <= 1;
        {i_low_red, i_low_green, i_low_blue} <= {a0, a1, a2};
        {i_high_red, i_high_green, i_high_blue} <= {b0, b1, b2};
        do @(posedge i_clk); while (!o_ready);
        sb.note_pair('{a0, a1, a2}, '{b0, b1, b2});
        @(negedge i_clk);
    endtask

    task automatic idle_tx();
        i_valid <= 0;
        @(negedge i_clk);
    endtask

    task automatic drain();
        int n;
        n = 0;
        i_valid <= 0;
        while (sb.pending.size() != 0) @(negedge i_clk);
        while (n < LATENCY + 5) begin
            @(negedge i_clk);
            n++;
        end
    endtask

    function automatic logic signed [VW-1:0] pick_value(longint unsigned lim);
        case ($urandom_range(0, 5))
            0: return VW'($urandom);
            1: return $urandom_range(0, 4) == 0 ? VAL_MIN : VAL_MAX;
            2: return VW'(lim + $urandom_range(0, 8) - 4);
            3: return VW'(int'($urandom_range(0, 8)) - 4);
            default: return $signed(20'($urandom_range(0, 32'(2 * lim + 2))))
                          - $signed(20'(lim / 2));
        endcase
    endfunction

    task automatic random_phase(int count);
        int burst;
        logic signed [VW-1:0] v[6];
        while (count > 0) begin
            burst = $urandom_range(1, 20);
            while (burst > 0 && count > 0) begin
                foreach (v[k]) v[k] = pick_value(sb.lim[k % 3]);
                send_pair(v[0], v[1], v[2], v[3], v[4], v[5]);
                burst--;
                count--;
            end
            if ($urandom_range(0, 2) == 0) begin
                repeat ($urandom_range(1, 6)) idle_tx();
            end
        end
    endtask

    initial begin
        logic [LW-1:0] settings[5][3];
        i_rst_n = 0;
        i_valid = 0;
        i_cfg_we = 0;
        i_cfg_index = REG_LIMIT_RED;
        i_cfg_data = 0;
        {i_low_red, i_low_green, i_low_blue} = 0;
        {i_high_red, i_high_green, i_high_blue} = 0;
        hold_rx = 0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1;
        @(negedge i_clk);

        // directed words at reset limits
        send_pair(0, 0, 0, 0, 0, 0);
        send_pair(VAL_MIN, VAL_MIN, VAL_MIN, VAL_MAX, VAL_MAX, VAL_MAX);
        send_pair(VAL_MAX, VAL_MAX, VAL_MAX, VAL_MIN, VAL_MIN, VAL_MIN);
        send_pair(-20'sd1, 20'sd100, 20'sd200, 20'sd1, 20'sd300, 20'sd400);
        send_pair(20'sd32768, 20'sd32768, 20'sd32768, -20'sd32768, 20'sd90000, 20'sd10);
        send_pair(20'sd70000, 20'sd1000, -20'sd5000, 20'sd1000, 20'sd70000, 20'sd70000);
        send_pair(20'sd65536, 20'sd65536, 20'sd65536, 20'sd65537, 20'sd0, -20'sd1);
        send_pair(-20'sd100, 20'sd70000, 20'sd20000, 20'sd70000, -20'sd100, 20'sd20000);
        send_pair(20'sd5, 20'sd5, 20'sd5, 20'sd5, 20'sd5, 20'sd5);
        send_pair(VAL_MIN, 20'sd0, VAL_MAX, VAL_MAX, 20'sd65536, VAL_MIN);
        send_pair(-20'sd3, 20'sd65539, 20'sd7, 20'sd1, 20'sd65535, -20'sd7);
        drain();

        // long receiver hold-off so the pipe fills and backpressures
        hold_rx = 1;
        fork
            random_phase(120);
            begin
                repeat (300) @(negedge i_clk);
                hold_rx = 0;
            end
        join
        drain();

        settings = '{'{19'h7FFFF, 19'h7FFFF, 19'h7FFFF}, '{0, 0, 0},
                     '{19'd1, 19'd131072, 19'd300000}, '{19'd40000, 19'd65536, 19'd1000},
                     '{19'd0, 19'h7FFFF, 19'd65535}};
        foreach (settings[s]) begin
            write_limit(REG_LIMIT_RED, settings[s][0]);
            write_limit(REG_LIMIT_GREEN, settings[s][1]);
            write_limit(REG_LIMIT_BLUE, settings[s][2]);
            if (s == 1) begin
                send_pair(0, 0, 0, 20'sd1, -20'sd1, 20'sd2);
                send_pair(VAL_MAX, 20'sd0, -20'sd9, 20'sd0, VAL_MAX, 20'sd9);
            end
            random_phase(130);
            drain();
        end
        write_limit(REG_LIMIT_RED, LW'($urandom_range(0, 200000)));
        write_limit(REG_LIMIT_GREEN, LW'($urandom_range(0, 200000)));
        write_limit(REG_LIMIT_BLUE, LW'($urandom_range(0, 200000)));
        random_phase(360);
        drain();

        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end
endmodule

`default_nettype wire
